### rtl/core/dhc_pkg.sv
// Shared types and codes for the dual hysteresis on/off controller.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package dhc_pkg;

  // channel / combined state codes
  localparam logic [1:0] ST_OFF  = 2'd0;
  localparam logic [1:0] ST_ON   = 2'd1;
  localparam logic [1:0] ST_IDLE = 2'd3;

  // input mode codes
  localparam logic [1:0] MODE_EVAL   = 2'd0;
  localparam logic [1:0] MODE_TICK_T = 2'd1;
  localparam logic [1:0] MODE_TICK_H = 2'd2;
  localparam logic [1:0] MODE_STOP   = 2'd3;

  // endpoints and commands
  localparam logic EP_TEMP = 1'b0;
  localparam logic EP_HUM  = 1'b1;
  localparam logic CMD_OFF = 1'b0;
  localparam logic CMD_ON  = 1'b1;

  // configuration register indexes
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_FLAGS    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_T_ACTION = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_H_ACTION = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_T_LOW    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_T_HIGH   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_H_LOW    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_H_HIGH   = 3'd6;

  // control_flags bits
  localparam int FLAG_TEMP_EN = 0;
  localparam int FLAG_HUM_EN  = 1;
  localparam int FLAG_REPEAT  = 2;
  localparam int FLAG_ONE_DEV = 3;

  // result queue depth: room for two results while two more wait
  localparam int QUEUE_DEPTH = 4;

  typedef struct packed {
    logic [1:0]         mode;
    logic               joined;
    logic               bind_idle;
    logic signed [15:0] temperature;
    logic [13:0]        humidity;
  } in_item_t;

  typedef struct packed {
    logic endpoint;
    logic command;
    logic last;
  } out_item_t;

  typedef struct packed {
    logic [3:0]         flags;
    logic               temp_action;
    logic               hum_action;
    logic signed [15:0] temp_low;
    logic signed [15:0] temp_high;
    logic [13:0]        hum_low;
    logic [13:0]        hum_high;
  } cfg_t;

  // up to two commands produced by one item, in order
  typedef struct packed {
    logic [1:0] n;
    logic [1:0] ep;
    logic [1:0] cmd;
  } em_t;

endpackage

`default_nettype wire

### rtl/core/dhc_ifs.sv
// Valid/ready channel interfaces for samples and commands.
// Depends on dhc_pkg.
`default_nettype none

interface dhc_sample_if;
  import dhc_pkg::*;
  logic               valid;
  logic               ready;
  logic [1:0]         mode;
  logic               joined;
  logic               bind_idle;
  logic signed [15:0] temperature;
  logic [13:0]        humidity;

  modport source (output valid, mode, joined, bind_idle, temperature, humidity,
                  input ready);
  modport sink (input valid, mode, joined, bind_idle, temperature, humidity,
                output ready);
endinterface

interface dhc_result_if;
  logic valid;
  logic ready;
  logic endpoint;
  logic command;
  logic last;

  modport source (output valid, endpoint, command, last, input ready);
  modport sink (input valid, endpoint, command, last, output ready);
endinterface

`default_nettype wire

### rtl/core/dual_hysteresis_onoff_controller_top.sv
// Dual hysteresis on/off controller: configuration registers, input stage,
// decision core and result queue. Depends on dhc_pkg, dhc_ifs, dhc_core and
// dhc_res_queue.
// A sample passes the input stage register, the core and the queue register
// before its first command goes out. Throughput: one item per cycle while
// each item gives at most one command and the result channel does not stall;
// two-command items are slowed by the single result channel draining the queue.
// Reset (synchronous): registers to zero, channels idle, timers off, queue empty.
`default_nettype none

module dual_hysteresis_onoff_controller_top (
  input  logic                               clk,
  input  logic                               rst,
  dhc_sample_if.sink                         sample,
  dhc_result_if.source                       result,
  input  logic                               wr_en,
  input  logic [dhc_pkg::CFG_IDX_W-1:0]      wr_index,
  input  logic [dhc_pkg::CFG_DATA_W-1:0]     wr_data
);
  import dhc_pkg::*;

  cfg_t      cfg;
  in_item_t  in_q;
  logic      in_v;
  logic      fire;
  logic      room2;
  em_t       em;
  out_item_t head;
  logic      head_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_FLAGS:    cfg.flags       <= wr_data[3:0];
        REG_T_ACTION: cfg.temp_action <= wr_data[0];
        REG_H_ACTION: cfg.hum_action  <= wr_data[0];
        REG_T_LOW:    cfg.temp_low    <= $signed(wr_data);
        REG_T_HIGH:   cfg.temp_high   <= $signed(wr_data);
        REG_H_LOW:    cfg.hum_low     <= wr_data[13:0];
        REG_H_HIGH:   cfg.hum_high    <= wr_data[13:0];
        default: ;
      endcase
    end
  end

  // input stage: holds one item until the queue has room for its commands
  assign fire         = in_v && room2;
  assign sample.ready = !in_v || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_v <= 1'b0;
    end else if (sample.ready) begin
      in_v <= sample.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sample.valid && sample.ready) begin
      in_q.mode        <= sample.mode;
      in_q.joined      <= sample.joined;
      in_q.bind_idle   <= sample.bind_idle;
      in_q.temperature <= sample.temperature;
      in_q.humidity    <= sample.humidity;
    end
  end

  dhc_core u_core (
    .clk  (clk),
    .rst  (rst),
    .fire (fire),
    .item (in_q),
    .cfg  (cfg),
    .em   (em)
  );

  dhc_res_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_en    (fire),
    .push       (em),
    .head       (head),
    .head_valid (head_valid),
    .head_taken (result.ready),
    .room2      (room2)
  );

  assign result.valid    = head_valid;
  assign result.endpoint = head.endpoint;
  assign result.command  = head.command;
  assign result.last     = head.last;

endmodule

`default_nettype wire

### rtl/core/dhc_core.sv
// Channel state, hysteresis decisions, combined-mode merge and repeat ticks.
// Evaluates one registered item per cycle while fire is high; depends on dhc_pkg.
`default_nettype none

module dhc_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             fire,
  input  dhc_pkg::in_item_t item,
  input  dhc_pkg::cfg_t    cfg,
  output dhc_pkg::em_t     em
);
  import dhc_pkg::*;

  localparam logic [15:0] DIV10_MUL   = 16'd52429;
  localparam int          DIV10_SHIFT = 19;

  typedef struct packed {
    logic [1:0]  st;
    logic        arm;
    logic        sav_we;
    logic [15:0] sav;
    logic        em_v;
    logic        em_cmd;
  } ev_t;

  function automatic em_t em_push(em_t e, logic ep, logic cmd);
    em_t r;
    r = e;
    if (e.n == 2'd0) begin
      r.ep[0]  = ep;
      r.cmd[0] = cmd;
      r.n      = 2'd1;
    end else if (e.n == 2'd1) begin
      r.ep[1]  = ep;
      r.cmd[1] = cmd;
      r.n      = 2'd2;
    end
    return r;
  endfunction

  // truncating divide by ten via reciprocal; exact for magnitudes below 40960 (12-bit quotient)
  function automatic logic signed [12:0] div10(logic signed [16:0] v);
    logic [16:0] mag;
    logic [32:0] prod;
    logic [11:0] q;
    mag  = v[16] ? 17'(-v) : 17'(v);
    prod = 33'(mag) * 33'(DIV10_MUL);
    q    = 12'(prod >> DIV10_SHIFT);
    return v[16] ? -$signed({1'b0, q}) : $signed({1'b0, q});
  endfunction

  function automatic ev_t eval_ch(logic [1:0] st, logic signed [16:0] x,
                                  logic signed [16:0] lo, logic signed [16:0] hi,
                                  logic act, logic en, logic one, logic rep,
                                  logic arm);
    ev_t  r;
    logic turn_on;
    r.st     = st;
    r.arm    = arm;
    r.sav_we = 1'b0;
    r.sav    = x[15:0];
    r.em_v   = 1'b0;
    r.em_cmd = CMD_OFF;
    turn_on  = act ? (x > lo) : (x < hi);
    if (!en) begin
      r.arm = 1'b0;
      if (!one) begin
        if (st == ST_ON) r.em_v = 1'b1;
        r.st = ST_IDLE;
      end
    end else begin
      if (!rep) r.arm = 1'b0;
      if (st == ST_IDLE) begin
        // first sample picks the starting state
        r.sav_we = 1'b1;
        r.st     = turn_on ? ST_ON : ST_OFF;
        if (!one) begin
          r.arm    = rep;
          r.em_v   = 1'b1;
          r.em_cmd = turn_on;
        end
      end else if (st == ST_OFF) begin
        if ((x >= hi && act) || (x <= lo && !act)) begin
          r.st     = ST_ON;
          r.sav_we = 1'b1;
          if (!one) begin
            r.arm    = rep;
            r.em_v   = 1'b1;
            r.em_cmd = CMD_ON;
          end
        end
      end else begin
        if ((x >= hi && !act) || (x <= lo && act)) begin
          r.st     = ST_OFF;
          r.sav_we = 1'b1;
          if (!one) begin
            r.arm    = rep;
            r.em_v   = 1'b1;
            r.em_cmd = CMD_OFF;
          end
        end
      end
    end
    return r;
  endfunction

  logic [1:0][1:0]    chst, chst_next;
  logic [1:0][1:0]    comb, comb_next;
  logic [1:0]         arm, arm_next;
  logic signed [15:0] sav_t, sav_t_next;
  logic [13:0]        sav_h, sav_h_next;

  logic te, he, rep, one;
  logic signed [16:0] xt, xh, tlo, thi, hlo, hhi;
  ev_t ev_t_r, ev_h_r;

  // repeat tick datapath, shared by both channels
  logic               tch;
  logic signed [16:0] tx, ts;
  logic signed [12:0] xq, sq;
  logic               tact, oen;
  logic               sa, sb;
  logic               cx;

  assign te  = cfg.flags[FLAG_TEMP_EN];
  assign he  = cfg.flags[FLAG_HUM_EN];
  assign rep = cfg.flags[FLAG_REPEAT];
  assign one = cfg.flags[FLAG_ONE_DEV];

  assign xt  = $signed({item.temperature[15], item.temperature});
  assign xh  = $signed({3'b000, item.humidity});
  assign tlo = $signed({cfg.temp_low[15], cfg.temp_low});
  assign thi = $signed({cfg.temp_high[15], cfg.temp_high});
  assign hlo = $signed({3'b000, cfg.hum_low});
  assign hhi = $signed({3'b000, cfg.hum_high});

  assign ev_t_r = eval_ch(chst[0], xt, tlo, thi, cfg.temp_action, te, one, rep, arm[0]);
  assign ev_h_r = eval_ch(chst[1], xh, hlo, hhi, cfg.hum_action, he, one, rep, arm[1]);

  assign tch  = (item.mode == MODE_TICK_H);
  assign tx   = tch ? xh : xt;
  assign ts   = tch ? $signed({3'b000, sav_h}) : $signed({sav_t[15], sav_t});
  assign xq   = div10(tx);
  assign sq   = div10(ts);
  assign tact = tch ? cfg.hum_action : cfg.temp_action;
  // each tick looks at the other channel's enable
  assign oen  = tch ? te : he;

  // in single-channel combined mode sa is the enabled channel
  assign sa = te ? EP_TEMP : EP_HUM;
  assign sb = ~sa;

  always_comb begin
    chst_next  = chst;
    comb_next  = comb;
    arm_next   = arm;
    sav_t_next = sav_t;
    sav_h_next = sav_h;
    em         = '0;
    cx         = 1'b0;
    unique case (item.mode) inside
      MODE_EVAL: begin
        if (!item.bind_idle && item.joined) begin
          chst_next[0] = ev_t_r.st;
          arm_next[0]  = ev_t_r.arm;
          if (ev_t_r.sav_we) sav_t_next = $signed(ev_t_r.sav);
          if (ev_t_r.em_v) em = em_push(em, EP_TEMP, ev_t_r.em_cmd);
          chst_next[1] = ev_h_r.st;
          arm_next[1]  = ev_h_r.arm;
          if (ev_h_r.sav_we) sav_h_next = ev_h_r.sav[13:0];
          if (ev_h_r.em_v) em = em_push(em, EP_HUM, ev_h_r.em_cmd);
          if (one) begin
            if (!te && !he) begin
              arm_next = '0;
              if (chst_next[0] == ST_ON || chst_next[1] == ST_ON)
                em = em_push(em, EP_TEMP, CMD_OFF);
              chst_next = {ST_IDLE, ST_IDLE};
              comb_next = {ST_IDLE, ST_IDLE};
            end else if (te && he) begin
              for (int c = 0; c < 2; c++) begin
                cx = 1'(c);
                if (chst_next[cx] == ST_ON && comb_next[cx] != ST_ON) begin
                  comb_next[cx] = ST_ON;
                  em            = em_push(em, cx, CMD_ON);
                  arm_next      = '0;
                  if (rep) arm_next[cx] = 1'b1;
                end
              end
              for (int c = 0; c < 2; c++) begin
                cx = 1'(c);
                if (chst_next[cx] == ST_OFF && comb_next[cx] != ST_OFF) begin
                  comb_next[cx] = ST_OFF;
                  // off goes out only once both channels agree
                  if (comb_next[~cx] == ST_OFF) begin
                    em       = em_push(em, cx, CMD_OFF);
                    arm_next = '0;
                    if (rep) arm_next[cx] = 1'b1;
                  end
                end
              end
            end else begin
              arm_next[sb] = 1'b0;
              if (chst_next[sb] == ST_ON && chst_next[sa] == ST_OFF)
                em = em_push(em, sb, CMD_OFF);
              chst_next[sb] = ST_IDLE;
              comb_next[sb] = ST_IDLE;
              if (chst_next[sa] == ST_ON && comb_next[sa] != ST_ON) begin
                comb_next[sa] = ST_ON;
                em            = em_push(em, sa, CMD_ON);
                arm_next[sa]  = 1'b0;
              end
              if (chst_next[sa] == ST_OFF && comb_next[sa] != ST_OFF) begin
                comb_next[sa] = ST_OFF;
                em            = em_push(em, sa, CMD_OFF);
                arm_next[sa]  = 1'b0;
              end
              if (!arm_next[sa] && rep) arm_next[sa] = 1'b1;
            end
          end
        end
      end
      MODE_TICK_T, MODE_TICK_H: begin
        if (arm[tch]) begin
          if (!rep) begin
            arm_next[tch] = 1'b0;
          end else if (chst[tch] != ST_OFF) begin
            if ((one && oen) || (xq >= sq && tact) || (xq <= sq && !tact))
              em = em_push(em, tch, CMD_ON);
          end else begin
            if ((one && oen) || (xq >= sq && !tact) || (xq <= sq && tact))
              em = em_push(em, tch, CMD_OFF);
          end
        end
      end
      MODE_STOP: begin
        arm_next  = '0;
        chst_next = {ST_IDLE, ST_IDLE};
        comb_next = {ST_IDLE, ST_IDLE};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chst  <= {ST_IDLE, ST_IDLE};
      comb  <= {ST_IDLE, ST_IDLE};
      arm   <= '0;
      sav_t <= '0;
      sav_h <= '0;
    end else if (fire) begin
      chst  <= chst_next;
      comb  <= comb_next;
      arm   <= arm_next;
      sav_t <= sav_t_next;
      sav_h <= sav_h_next;
    end
  end

endmodule

`default_nettype wire

### rtl/core/dhc_res_queue.sv
// Small result queue: takes up to two commands per cycle while it has room, hands out one.
// Depends on dhc_pkg.
`default_nettype none

module dhc_res_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push_en,
  input  dhc_pkg::em_t       push,
  output dhc_pkg::out_item_t head,
  output logic               head_valid,
  input  logic               head_taken,
  output logic               room2
);
  import dhc_pkg::*;

  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  out_item_t q [QUEUE_DEPTH];
  out_item_t q_next [QUEUE_DEPTH];
  logic [CW-1:0] count, count_next, cnt_ap;
  logic          pop;

  assign head_valid = (count != '0);
  assign head       = q[0];
  assign pop        = head_valid && head_taken;
  assign cnt_ap     = count - CW'(pop);
  // decided from the registered count only, so ready does not follow ready
  assign room2      = (count <= CW'(QUEUE_DEPTH - 2));

  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH - 1; i++)
      q_next[i] = pop ? q[i+1] : q[i];
    q_next[QUEUE_DEPTH-1] = q[QUEUE_DEPTH-1];
    count_next = cnt_ap;
    if (push_en) begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
        if (push.n != 2'd0 && CW'(i) == cnt_ap)
          q_next[i] = '{endpoint: push.ep[0], command: push.cmd[0],
                        last: (push.n == 2'd1)};
        if (push.n == 2'd2 && CW'(i) == cnt_ap + CW'(1))
          q_next[i] = '{endpoint: push.ep[1], command: push.cmd[1], last: 1'b1};
      end
      count_next = cnt_ap + CW'(push.n);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < QUEUE_DEPTH; i++)
      q[i] <= q_next[i];
  end

endmodule

`default_nettype wire
